[sv/protobuf_varint_fixed_decoder_assert.svh]
// Assertion macros for the protobuf scalar decoder.
// Depends on nothing; the including module supplies clk and rst.
`ifndef PROTOBUF_VARINT_FIXED_DECODER_ASSERT_SVH
`define PROTOBUF_VARINT_FIXED_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define PVD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PVD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PVD_ASSERT(label, prop, msg)
`define PVD_ASSERT_RST(label, prop, msg)
`endif
`endif

[sv/pvd_pkg.sv]
// Shared codes and constants for the protobuf scalar decoder.
// Has no dependencies.
`default_nettype none

package pvd_pkg;

  localparam logic [2:0] KIND_V32  = 3'd0;
  localparam logic [2:0] KIND_V64  = 3'd1;
  localparam logic [2:0] KIND_F32  = 3'd2;
  localparam logic [2:0] KIND_F64  = 3'd3;
  localparam logic [2:0] KIND_BOOL = 3'd4;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MALFORMED = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;

  localparam logic [3:0] V32_LAST_BYTE = 4'd4;
  localparam logic [3:0] VMAX_LAST     = 4'd9;
  localparam logic [3:0] F32_LAST      = 4'd3;
  localparam logic [3:0] F64_LAST      = 4'd7;

endpackage

`default_nettype wire

[sv/protobuf_varint_fixed_decoder.sv]
// Top level of the streaming protobuf scalar decoder (varint, fixed, bool).
// Depends on pvd_pkg and protobuf_varint_fixed_decoder_assert.svh.
//
//   channel | signals                              | direction
//   input   | data_valid data_ready func data_byte | one byte per transfer
//   result  | result_valid result_ready value error| one transfer per value
//   config  | cfg_wen cfg_wdata                    | buffer length write
//
// One byte per cycle is sustained unless the result stalls; a byte is
// registered on acceptance, then decoded into the registered result port.
// The decode state lives in one register set updated by the decode stage.
// A stalled result holds the decode stage; the input register still fills.
// Synchronous reset clears the valid flags, decode state and buffer length.
`default_nettype none
`include "protobuf_varint_fixed_decoder_assert.svh"

module protobuf_varint_fixed_decoder
  import pvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [30:0] cfg_wdata,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [63:0] value,
  output logic [1:0]  error
);

  logic        s1_valid;
  logic [2:0]  s1_func;
  logic [7:0]  s1_byte;

  logic [30:0] length_limit;
  logic [30:0] position;
  logic [63:0] accumulator;
  logic [3:0]  byte_count;
  logic [2:0]  latched_kind;
  logic        discarding;
  logic        truncated;

  logic        out_free;
  logic        s1_fire;
  logic        first;
  logic [2:0]  kind;
  logic [63:0] acc_base;
  logic        disc_base;
  logic        at_end;
  logic [7:0]  b;
  logic [5:0]  shift7;
  logic [63:0] group7;
  logic [63:0] accumulator_next;
  logic        discarding_next;
  logic        truncated_next;
  logic        done;
  logic        malformed;
  logic [63:0] result_value;

  assign out_free   = !result_valid || result_ready;
  assign s1_fire    = s1_valid && out_free;
  assign data_ready = !s1_valid || out_free;

  always_comb begin
    first = (byte_count == 4'd0);
    if (!first) begin
      kind = latched_kind;
    end else if (s1_func > KIND_BOOL) begin
      kind = KIND_V32;
    end else begin
      kind = s1_func;
    end
    acc_base       = first ? 64'd0 : accumulator;
    disc_base      = first ? 1'b0 : discarding;
    at_end         = (position >= length_limit);
    b              = at_end ? 8'd0 : s1_byte;
    truncated_next = (first ? 1'b0 : truncated) || at_end;
    shift7         = {2'b00, byte_count} * 6'd7;
    group7         = {57'd0, b[6:0]} << shift7;

    accumulator_next = acc_base;
    discarding_next  = disc_base;
    done             = 1'b0;
    malformed        = 1'b0;
    unique case (kind)
      KIND_V64: begin
        accumulator_next = acc_base | group7;
        if (!b[7]) begin
          done = 1'b1;
        end else if (byte_count >= VMAX_LAST) begin
          done             = 1'b1;
          malformed        = 1'b1;
          accumulator_next = 64'd0;
        end
      end
      KIND_F32: begin
        accumulator_next = acc_base | ({56'd0, b} << {byte_count[1:0], 3'b000});
        done             = (byte_count >= F32_LAST);
      end
      KIND_F64: begin
        accumulator_next = acc_base | ({56'd0, b} << {byte_count[2:0], 3'b000});
        done             = (byte_count >= F64_LAST);
      end
      default: begin
        if (disc_base) begin
          if (!b[7]) begin
            done = 1'b1;
          end else if (byte_count >= VMAX_LAST) begin
            done      = 1'b1;
            malformed = 1'b1;
          end
        end else if (byte_count < V32_LAST_BYTE) begin
          accumulator_next = acc_base | group7;
          done             = !b[7];
        end else begin
          accumulator_next = acc_base | {32'd0, b[3:0], 28'd0};
          if (b[7]) begin
            discarding_next = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
      end
    endcase

    if (kind == KIND_V32) begin
      result_value = {32'd0, accumulator_next[31:0]};
    end else if (kind == KIND_BOOL) begin
      result_value = {63'd0, |accumulator_next[31:0]};
    end else begin
      result_value = accumulator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data_valid && data_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
    if (data_valid && data_ready) begin
      s1_func <= func;
      s1_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= 31'd0;
    end else if (cfg_wen) begin
      length_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= 31'd0;
      accumulator  <= 64'd0;
      byte_count   <= 4'd0;
      latched_kind <= KIND_V32;
      discarding   <= 1'b0;
      truncated    <= 1'b0;
    end else if (s1_fire) begin
      if (!at_end) begin
        position <= position + 31'd1;
      end
      latched_kind <= kind;
      if (done) begin
        accumulator <= 64'd0;
        byte_count  <= 4'd0;
        discarding  <= 1'b0;
        truncated   <= 1'b0;
      end else begin
        accumulator <= accumulator_next;
        byte_count  <= byte_count + 4'd1;
        discarding  <= discarding_next;
        truncated   <= truncated_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire && done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (s1_fire && done) begin
      value <= result_value;
      if (malformed) begin
        error <= ERR_MALFORMED;
      end else if (truncated_next) begin
        error <= ERR_TRUNCATED;
      end else begin
        error <= ERR_NONE;
      end
    end
  end

  `PVD_ASSERT(a_count_bound, byte_count <= VMAX_LAST, "byte count ran past ten bytes")
  `PVD_ASSERT(a_discard_count, discarding |-> byte_count > V32_LAST_BYTE,
              "discarding before the fifth byte")
  `PVD_ASSERT(a_trunc_open, truncated |-> byte_count != 4'd0,
              "truncation flag left over from a finished value")
  `PVD_ASSERT(a_error_code, result_valid |-> error != 2'd3, "undefined error code")
  `PVD_ASSERT_RST(a_reset_clear, rst |=> !result_valid && !s1_valid,
                  "pipeline not empty after reset")

endmodule

`default_nettype wire

[tb/sv/pvd_decode_checker.sv]
`timescale 1ns / 100ps
// Checker for the protobuf scalar decoder: watches the byte, result and length ports,
// predicts each decoded value and compares it with what the decoder returns.
// Depends on pvd_pkg.
module pvd_decode_checker
  import pvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [30:0] cfg_wdata,
  input  logic        data_valid,
  input  logic        data_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  data_byte,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [63:0] value,
  input  logic [1:0]  error,
  output int          mismatch_count,
  output int          values_outstanding,
  output logic [30:0] stream_position
);

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  error;
  } decoded_t;

  decoded_t    expected_values[$];
  logic [63:0] acc;
  logic [3:0]  byte_idx;
  logic [2:0]  cur_kind;
  logic        skipping;
  logic        hit_end;
  logic [30:0] buffer_len;

  function automatic bit decode_byte(input logic [2:0] kind_in, input logic [7:0] raw,
                                     output decoded_t res);
    logic [7:0] b;
    bit done;
    bit bad;
    done = 1'b0;
    bad = 1'b0;
    res = '0;
    if (byte_idx == 4'd0) begin
      cur_kind = (kind_in > KIND_BOOL) ? KIND_V32 : kind_in;
      acc = '0;
      skipping = 1'b0;
      hit_end = 1'b0;
    end
    if (stream_position >= buffer_len) begin
      b = 8'h00;
      hit_end = 1'b1;
    end else begin
      b = raw;
      stream_position = stream_position + 31'd1;
    end
    case (cur_kind)
      KIND_V64: begin
        acc |= {57'd0, b[6:0]} << (7 * byte_idx);
        if (!b[7]) begin
          done = 1'b1;
        end else if (byte_idx >= VMAX_LAST) begin
          done = 1'b1;
          bad = 1'b1;
          acc = '0;
        end
      end
      KIND_F32: begin
        acc |= {56'd0, b} << (8 * byte_idx[1:0]);
        done = (byte_idx >= F32_LAST);
      end
      KIND_F64: begin
        acc |= {56'd0, b} << (8 * byte_idx[2:0]);
        done = (byte_idx >= F64_LAST);
      end
      default: begin
        if (skipping) begin
          if (!b[7]) begin
            done = 1'b1;
          end else if (byte_idx >= VMAX_LAST) begin
            done = 1'b1;
            bad = 1'b1;
          end
        end else if (byte_idx < V32_LAST_BYTE) begin
          acc |= {57'd0, b[6:0]} << (7 * byte_idx);
          done = !b[7];
        end else begin
          acc |= {60'd0, b[3:0]} << 28;
          if (b[7]) skipping = 1'b1;
          else done = 1'b1;
        end
      end
    endcase
    if (!done) begin
      byte_idx = byte_idx + 4'd1;
      return 1'b0;
    end
    res.value = acc;
    if (cur_kind == KIND_V32) res.value = {32'd0, acc[31:0]};
    else if (cur_kind == KIND_BOOL) res.value = {63'd0, |acc[31:0]};
    res.error = bad ? ERR_MALFORMED : (hit_end ? ERR_TRUNCATED : ERR_NONE);
    acc = '0;
    byte_idx = 4'd0;
    skipping = 1'b0;
    hit_end = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    decoded_t want;
    if (rst) begin
      expected_values.delete();
      acc = '0;
      byte_idx = 4'd0;
      cur_kind = KIND_V32;
      skipping = 1'b0;
      hit_end = 1'b0;
      buffer_len = '0;
      stream_position = '0;
      mismatch_count = 0;
    end else begin
      if (cfg_wen) buffer_len = cfg_wdata;
      if (data_valid && data_ready) begin
        if (decode_byte(func, data_byte, want)) expected_values.push_back(want);
      end
      if (result_valid && result_ready) begin
        if (expected_values.size() == 0) begin
          $error("unexpected result transfer: value %h error %0d", value, error);
          mismatch_count++;
        end else begin
          want = expected_values.pop_front();
          if (value !== want.value) begin
            $error("value mismatch: expected %h, actual %h", want.value, value);
            mismatch_count++;
          end
          if (error !== want.error) begin
            $error("error mismatch: expected %0d, actual %0d", want.error, error);
            mismatch_count++;
          end
        end
      end
    end
    values_outstanding = expected_values.size();
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Top of the protobuf scalar decoder testbench: clock, reset, byte stimulus, result
// back-pressure and the verdict. Depends on pvd_pkg, pvd_decode_checker, the decoder.
module testbench;
  import pvd_pkg::*;

  localparam logic [2:0]  KIND_UNUSED_HI = 3'd7;
  localparam logic [30:0] LENGTH_MAX     = 31'h7fffffff;
  localparam logic [30:0] LENGTH_EMPTY   = 31'd0;
  localparam int          LONG_STALL     = 150;
  localparam int          DRAIN_CYCLES   = 4;
  localparam logic [2:0]  VALUE_KINDS[5] = '{KIND_V32, KIND_V64, KIND_F32, KIND_F64, KIND_BOOL};

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wen;
  logic [30:0] cfg_wdata;
  logic        data_valid;
  logic        data_ready;
  logic [2:0]  func;
  logic [7:0]  data_byte;
  logic        result_valid;
  logic        result_ready;
  logic [63:0] value;
  logic [1:0]  error;
  int          mismatch_count;
  int          values_outstanding;
  logic [30:0] stream_position;

  bit tx_gaps_on;
  bit rx_gaps_on;
  bit long_stall_req;
  int sent_bytes;

  protobuf_varint_fixed_decoder dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .data_valid(data_valid), .data_ready(data_ready), .func(func), .data_byte(data_byte),
    .result_valid(result_valid), .result_ready(result_ready), .value(value), .error(error)
  );

  pvd_decode_checker decode_check (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .data_valid(data_valid), .data_ready(data_ready), .func(func), .data_byte(data_byte),
    .result_valid(result_valid), .result_ready(result_ready), .value(value), .error(error),
    .mismatch_count(mismatch_count), .values_outstanding(values_outstanding),
    .stream_position(stream_position)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_octet();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [2:0] k, input logic [7:0] b);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_valid <= 1'b1;
    func <= k;
    data_byte <= b;
    @(posedge clk);
    while (!data_ready) @(posedge clk);
    sent_bytes++;
  endtask

  // Mostly well-formed values with random content; a few stray bytes and
  // overlong varints break the framing.
  task automatic send_random_value();
    int pick;
    int len;
    logic [2:0] k;
    logic [7:0] b;
    bit overlong;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_byte(3'($urandom_range(0, 7)), 8'($urandom));
      return;
    end
    pick = $urandom_range(0, 11);
    k = (pick < 10) ? VALUE_KINDS[pick % 5]
                    : 3'($urandom_range(KIND_BOOL + 1, KIND_UNUSED_HI));
    overlong = 1'b0;
    if (k == KIND_F32) begin
      len = 4;
    end else if (k == KIND_F64) begin
      len = 8;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 60) len = $urandom_range(1, 4);
      else if (pick < 78) len = (k == KIND_V64) ? $urandom_range(5, 10) : 5;
      else if (pick < 92) len = $urandom_range(6, 10);
      else begin
        len = 10;
        overlong = 1'b1;
      end
    end
    for (int i = 0; i < len; i++) begin
      b = pick_octet();
      if (k != KIND_F32 && k != KIND_F64) b[7] = (i < len - 1) || overlong;
      send_byte((i == 0) ? k : 3'($urandom_range(0, 7)), b);
    end
  endtask

  task automatic send_random_bytes(input int count);
    int target;
    target = sent_bytes + count;
    while (sent_bytes < target) send_random_value();
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    data_valid <= 1'b0;
    @(posedge clk);
    while (values_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [30:0] len);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    result_ready = 1'b0;
    forever begin : receiver
      int gap;
      @(negedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        result_ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
      end
      gap = rx_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ready <= 1'b1;
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] octet;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    data_valid = 1'b0;
    func = KIND_V32;
    data_byte = 8'h00;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    long_stall_req = 1'b0;
    sent_bytes = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The buffer is empty after reset, so every byte reads as zero.
    send_byte(KIND_V32, 8'h85);
    send_byte(KIND_BOOL, 8'hff);
    wait_for_drain();

    write_length(LENGTH_MAX);
    send_byte(KIND_V32, 8'h00);
    send_byte(KIND_BOOL, 8'h01);
    send_byte(KIND_UNUSED_HI, 8'h7f);
    for (int i = 0; i < 4; i++) send_byte((i == 0) ? KIND_F32 : KIND_F64, 8'hff);
    for (int i = 0; i < 10; i++) send_byte(KIND_V64, (i < 9) ? 8'hff : 8'h01);
    for (int i = 0; i < 6; i++) begin
      octet = (i < 4) ? 8'hff : ((i == 4) ? 8'h8f : 8'h00);
      send_byte(KIND_V32, octet);
    end
    wait_for_drain();

    // Hold the result side off while single-byte values keep coming.
    tx_gaps_on = 1'b0;
    long_stall_req = 1'b1;
    repeat (40) begin
      octet = pick_octet();
      octet[7] = 1'b0;
      send_byte(KIND_V32, octet);
    end
    tx_gaps_on = 1'b1;
    send_random_bytes(320);
    wait_for_drain();

    // The buffer end falls a few bytes ahead, cutting values short.
    repeat (3) begin
      write_length(stream_position + 31'($urandom_range(0, 12)));
      send_random_bytes(50);
      wait_for_drain();
    end

    write_length(LENGTH_MAX);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    send_random_bytes(200);
    wait_for_drain();

    write_length(LENGTH_EMPTY);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    send_random_bytes(20);
    wait_for_drain();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && values_outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
